>>> rtl/core/energy_voice_endpoint_detector_defines.svh
// ----------------------------------------------------------------------------
// Energy voice endpoint detector assertion macros
// Shared same-cycle and next-cycle implication check macros for the detector.
// ----------------------------------------------------------------------------
`ifndef ENERGY_VOICE_ENDPOINT_DETECTOR_DEFINES_SVH
`define ENERGY_VOICE_ENDPOINT_DETECTOR_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define EVEPD_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define EVEPD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/evepd_pkg.sv
// ----------------------------------------------------------------------------
// Energy voice endpoint detector package
// Field widths, register indexes, reset values, outcome codes and result type.
// ----------------------------------------------------------------------------
package evepd_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int ADDR_W     = 17;
  localparam int LEN_W      = 9;
  localparam int START_W    = 8;
  localparam int OUTCOME_W  = 2;
  localparam int CNT_W      = 12;
  localparam int PRE_W      = 9;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 40;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_THR  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRE_ROLL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEECH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_SILENCE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEECH  = 3'd4;

  // Register reset values.
  localparam logic [CFG_DATA_W-1:0] ENERGY_THR_RST  = 16'd300;
  localparam logic [PRE_W-1:0]      PRE_ROLL_RST    = 9'd14;
  localparam logic [CNT_W-1:0]      MIN_SPEECH_RST  = 12'd9;
  localparam logic [CNT_W-1:0]      END_SILENCE_RST = 12'd38;
  localparam logic [CNT_W-1:0]      MAX_SPEECH_RST  = 12'd234;

  // Outcome codes.
  localparam logic [OUTCOME_W-1:0] OUTCOME_NONE    = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_SPEECH  = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_BUTTON  = 2'd2;
  localparam logic [OUTCOME_W-1:0] OUTCOME_TIMEOUT = 2'd3;

  // Input kinds carried on in_tuser.
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_ARM    = 1'b1;

  typedef struct packed {
    logic [START_W-1:0]   start;
    logic [LEN_W-1:0]     len;
    logic [OUTCOME_W-1:0] outcome;
    logic                 done;
    logic [ADDR_W-1:0]    addr;
    logic                 en;
  } res_t;

endpackage

>>> rtl/core/energy_voice_endpoint_detector.sv
// ----------------------------------------------------------------------------
// Energy voice endpoint detector
// Frames PCM samples, flags loud frames and marks where a spoken phrase lies
// in a circular capture store.
// ----------------------------------------------------------------------------
// Usage: the input stream carries one request per item. in_tuser selects the
// kind: a PCM sample, or an arm request that starts a new capture. Every
// accepted request yields exactly one result on the output stream, telling
// the caller whether and where to store the sample and, on the last item of a
// capture (out_tlast), why it ended and where the recording lies.
// A request's result is registered in the output register. Throughput is one
// request per cycle while the skid register is empty; the whole per-sample
// update (magnitude accumulate, loudness compare against a pre-scaled
// threshold, frame counters and the start-frame wrap) fits between the input
// handshake and the output register.
// When the receiver stalls, one more result is parked in a skid register and
// in_tready is low while that register is full.
// Reset (rst_n low, synchronous) returns the detector to idle, clears all
// counters and the button latch, and loads the default register values.
// Configuration writes take effect at the edge where cfg_we is high.
// ----------------------------------------------------------------------------
`include "energy_voice_endpoint_detector_defines.svh"

module energy_voice_endpoint_detector #(
  parameter int FRAME_SAMPLES  = 512,
  parameter int CAPTURE_FRAMES = 256
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Configuration write port
  input  logic                               cfg_we,
  input  logic [evepd_pkg::CFG_IDX_W-1:0]    cfg_addr,
  input  logic [evepd_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  // Input stream
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // in_tdata, low bit up: sample[15:0], button[16], deadline_passed[17], zero
  input  logic [evepd_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: op[0]
  input  logic                               in_tuser,
  // Result stream
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // out_tdata, low bit up: store_enable[0], store_address[17:1],
  // length_frames[26:18], start_frame[34:27], zero
  output logic [evepd_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: outcome[1:0]
  output logic [evepd_pkg::OUTCOME_W-1:0]    out_tuser,
  // out_tlast: done_res, the capture finished with this item
  output logic                               out_tlast
);

  import evepd_pkg::*;

  localparam int SIF_W  = $clog2(FRAME_SAMPLES);
  localparam int SUM_W  = SIF_W + SAMPLE_W;
  localparam int WF_W   = $clog2(CAPTURE_FRAMES);
  localparam int KEPT_W = $clog2(CAPTURE_FRAMES + 1);
  localparam int KW     = (KEPT_W > PRE_W) ? KEPT_W : PRE_W;
  localparam int PW     = WF_W + SIF_W;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_WAIT   = 2'd1,
    MODE_SPEECH = 2'd2
  } mode_t;

  // Configuration. The threshold is held pre-multiplied by the frame length
  // so that the loudness test compares the raw frame sum.
  logic [SUM_W-1:0]  thr_scaled_r;
  logic [PRE_W-1:0]  pre_roll_r;
  logic [CNT_W-1:0]  min_speech_r;
  logic [CNT_W-1:0]  end_silence_r;
  logic [CNT_W-1:0]  max_speech_r;

  // Capture state.
  mode_t             mode_r,    mode_nxt;
  logic [SIF_W-1:0]  sif_r,     sif_nxt;
  logic [SUM_W-1:0]  sum_r,     sum_nxt;
  logic [WF_W-1:0]   wf_r,      wf_nxt;
  logic [KEPT_W-1:0] kept_r,    kept_nxt;
  logic [CNT_W-1:0]  speech_r,  speech_nxt;
  logic [CNT_W-1:0]  silent_r,  silent_nxt;
  logic              latch_r,   latch_nxt;

  // Output register and skid register.
  logic              out_valid_r;
  res_t              out_res_r;
  logic              skid_valid_r;
  res_t              skid_res_r;

  logic              in_fire;
  logic              out_fire;
  res_t              res_c;

  // Unpacked request fields.
  logic                op;
  logic [SAMPLE_W-1:0] sample;
  logic                button;
  logic                deadline;

  // Datapath helpers.
  logic                latch_eff;
  logic [SAMPLE_W-1:0] mag;
  logic [SUM_W-1:0]    sum_add;
  logic                loud;
  logic                frame_end;
  logic                store_en;
  logic [PW-1:0]       addr_prod;
  logic [PW+ADDR_W-1:0] addr_ext;
  logic [WF_W-1:0]     wf_inc;
  logic [KW-1:0]       keep;
  logic [KW:0]         kept_plus;
  logic [KEPT_W-1:0]   kept_wait;
  logic [WF_W-1:0]     wf_sp;
  logic [KEPT_W-1:0]   kept_sp;
  logic [CNT_W-1:0]    speech_inc;
  logic [CNT_W-1:0]    silent_new;
  logic                ended;
  logic                full;
  logic [KEPT_W-1:0]   kept_mod;
  logic [WF_W:0]       start_t;
  logic [WF_W:0]       start_w;
  logic [WF_W+START_W:0] start_ext;
  logic [KEPT_W+LEN_W-1:0] len_ext;

  assign op       = in_tuser;
  assign sample   = in_tdata[SAMPLE_W-1:0];
  assign button   = in_tdata[SAMPLE_W];
  assign deadline = in_tdata[SAMPLE_W+1];

  assign in_tready = !skid_valid_r;
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_valid_r && out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - ADDR_W - LEN_W - START_W - 1){1'b0}},
                       out_res_r.start, out_res_r.len, out_res_r.addr, out_res_r.en};
  assign out_tuser  = out_res_r.outcome;
  assign out_tlast  = out_res_r.done;

  // ---------------------------------------------------------------------
  // Per-sample arithmetic
  // ---------------------------------------------------------------------
  assign latch_eff = latch_r | button;

  // Magnitude of a 16-bit sample; the most negative value maps to 0x8000.
  assign mag     = sample[SAMPLE_W-1] ? (~sample + 1'b1) : sample;
  assign sum_add = sum_r + SUM_W'(mag);
  assign loud    = (sum_add >= thr_scaled_r);

  assign frame_end = (sif_r == SIF_W'(FRAME_SAMPLES - 1));
  assign store_en  = (mode_r == MODE_WAIT) || (kept_r < KEPT_W'(CAPTURE_FRAMES));

  assign addr_prod = PW'(wf_r) * PW'(FRAME_SAMPLES) + PW'(sif_r);
  assign addr_ext  = {{ADDR_W{1'b0}}, addr_prod};

  assign wf_inc = (wf_r == WF_W'(CAPTURE_FRAMES - 1)) ? '0 : wf_r + 1'b1;

  // Pre-roll depth: zero counts as one, and never more than the store holds.
  always_comb begin
    if (pre_roll_r == '0) begin
      keep = KW'(1);
    end else if (KW'(pre_roll_r) > KW'(CAPTURE_FRAMES)) begin
      keep = KW'(CAPTURE_FRAMES);
    end else begin
      keep = KW'(pre_roll_r);
    end
  end

  assign kept_plus = (KW+1)'(kept_r) + 1'b1;
  assign kept_wait = (kept_plus > (KW+1)'(keep)) ? KEPT_W'(keep) : KEPT_W'(kept_plus);

  // Speech-phase frame end.
  assign wf_sp      = store_en ? wf_inc : wf_r;
  assign kept_sp    = store_en ? kept_r + 1'b1 : kept_r;
  assign speech_inc = (speech_r == CNT_MAX) ? speech_r : speech_r + 1'b1;
  assign silent_new = loud ? '0 : ((silent_r == CNT_MAX) ? silent_r : silent_r + 1'b1);
  assign ended      = (speech_inc >= min_speech_r) && (silent_new >= end_silence_r);
  assign full       = (speech_inc >= max_speech_r) || (kept_sp >= KEPT_W'(CAPTURE_FRAMES));

  // First frame of the recording, wrapped around the store.
  assign kept_mod  = (kept_sp == KEPT_W'(CAPTURE_FRAMES)) ? '0 : kept_sp;
  assign start_t   = {1'b0, wf_sp} + (WF_W+1)'(CAPTURE_FRAMES) - (WF_W+1)'(kept_mod);
  assign start_w   = (start_t >= (WF_W+1)'(CAPTURE_FRAMES)) ?
                     start_t - (WF_W+1)'(CAPTURE_FRAMES) : start_t;
  assign start_ext = {{START_W{1'b0}}, start_w};
  assign len_ext   = {{LEN_W{1'b0}}, kept_sp};

  // ---------------------------------------------------------------------
  // Next state and result for one request
  // ---------------------------------------------------------------------
  always_comb begin
    mode_nxt   = mode_r;
    sif_nxt    = sif_r;
    sum_nxt    = sum_r;
    wf_nxt     = wf_r;
    kept_nxt   = kept_r;
    speech_nxt = speech_r;
    silent_nxt = silent_r;
    latch_nxt  = latch_eff;
    res_c      = '0;

    if (op == OP_ARM) begin
      // Arming restarts any capture in progress.
      mode_nxt   = MODE_WAIT;
      sif_nxt    = '0;
      sum_nxt    = '0;
      wf_nxt     = '0;
      kept_nxt   = '0;
      speech_nxt = '0;
      silent_nxt = '0;
    end else if (mode_r == MODE_IDLE) begin
      // Samples outside a capture are dropped.
    end else if ((sif_r == '0) && latch_eff) begin
      latch_nxt     = 1'b0;
      mode_nxt      = MODE_IDLE;
      res_c.done    = 1'b1;
      res_c.outcome = OUTCOME_BUTTON;
    end else if ((sif_r == '0) && (mode_r == MODE_WAIT) && deadline) begin
      mode_nxt      = MODE_IDLE;
      res_c.done    = 1'b1;
      res_c.outcome = OUTCOME_TIMEOUT;
    end else begin
      res_c.en   = store_en;
      res_c.addr = store_en ? addr_ext[ADDR_W-1:0] : '0;
      if (!frame_end) begin
        sif_nxt = sif_r + 1'b1;
        sum_nxt = sum_add;
      end else begin
        sif_nxt = '0;
        sum_nxt = '0;
        if (mode_r == MODE_WAIT) begin
          wf_nxt   = wf_inc;
          kept_nxt = kept_wait;
          // No end test on the onset frame itself.
          if (loud) begin
            mode_nxt   = MODE_SPEECH;
            speech_nxt = '0;
            silent_nxt = '0;
          end
        end else begin
          wf_nxt     = wf_sp;
          kept_nxt   = kept_sp;
          speech_nxt = speech_inc;
          silent_nxt = silent_new;
          if (ended || full) begin
            mode_nxt      = MODE_IDLE;
            res_c.done    = 1'b1;
            res_c.outcome = OUTCOME_SPEECH;
            res_c.len     = len_ext[LEN_W-1:0];
            res_c.start   = start_ext[START_W-1:0];
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_scaled_r  <= SUM_W'(ENERGY_THR_RST) * SUM_W'(FRAME_SAMPLES);
      pre_roll_r    <= PRE_ROLL_RST;
      min_speech_r  <= MIN_SPEECH_RST;
      end_silence_r <= END_SILENCE_RST;
      max_speech_r  <= MAX_SPEECH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_ENERGY_THR:  thr_scaled_r  <= SUM_W'(cfg_wdata) * SUM_W'(FRAME_SAMPLES);
        REG_PRE_ROLL:    pre_roll_r    <= cfg_wdata[PRE_W-1:0];
        REG_MIN_SPEECH:  min_speech_r  <= cfg_wdata[CNT_W-1:0];
        REG_END_SILENCE: end_silence_r <= cfg_wdata[CNT_W-1:0];
        REG_MAX_SPEECH:  max_speech_r  <= cfg_wdata[CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // Capture state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_IDLE;
      sif_r    <= '0;
      sum_r    <= '0;
      wf_r     <= '0;
      kept_r   <= '0;
      speech_r <= '0;
      silent_r <= '0;
      latch_r  <= 1'b0;
    end else if (in_fire) begin
      mode_r   <= mode_nxt;
      sif_r    <= sif_nxt;
      sum_r    <= sum_nxt;
      wf_r     <= wf_nxt;
      kept_r   <= kept_nxt;
      speech_r <= speech_nxt;
      silent_r <= silent_nxt;
      latch_r  <= latch_nxt;
    end
  end

  // ---------------------------------------------------------------------
  // Output register with skid stage
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_fire) begin
        skid_valid_r <= 1'b0;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (out_fire) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_fire) begin
        out_res_r <= skid_res_r;
      end
    end else if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_res_r <= res_c;
      end else begin
        skid_res_r <= res_c;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `EVEPD_ASSERT_SAME(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full over empty output")
  `EVEPD_ASSERT_NEXT(a_done_idle, in_fire && res_c.done, mode_r == MODE_IDLE, "busy after done")
  `EVEPD_ASSERT_SAME(a_kept_bounded, 1'b1, kept_r <= KEPT_W'(CAPTURE_FRAMES), "kept too big")
  `EVEPD_ASSERT_SAME(a_addr_gate, out_valid_r && !out_res_r.en, out_res_r.addr == '0, "stray addr")

endmodule

>>> bench/energy_voice_endpoint_detector_tb.sv
// ----------------------------------------------------------------------------
// Energy voice endpoint detector testbench
// Streams arm and sample requests through the detector under random stalls on
// both sides. A built-in predictor of the framing, loudness and endpoint logic
// checks every result field by field.
// ----------------------------------------------------------------------------
module energy_voice_endpoint_detector_tb;
  import evepd_pkg::*;

  localparam int FRAME_LEN    = 512;
  localparam int STORE_FRAMES = 256;
  localparam int SAT_LIMIT    = 4095;
  // A correct run finishes well within this limit even with every stall at its
  // longest; the limit leaves a wide margin on top of that.
  localparam longint RUN_LIMIT = 64'd5_000_000;

  // Capture progress as the predictor tracks it.
  typedef enum logic [1:0] {
    CAP_IDLE,
    CAP_WAIT,
    CAP_SPEECH
  } cap_mode_t;

  // One request on the input stream, before packing.
  typedef struct packed {
    logic        op;
    logic        late;
    logic        btn;
    logic [15:0] pcm;
  } audio_req_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  in_tuser;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUTCOME_W-1:0]  out_tuser;
  logic                  out_tlast;

  energy_voice_endpoint_detector #(
    .FRAME_SAMPLES (FRAME_LEN),
    .CAPTURE_FRAMES(STORE_FRAMES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // Requests waiting for the driver, and results the detector still owes.
  audio_req_t pcm_backlog[$];
  res_t       sample_verdicts[$];

  int  reqs_queued;
  int  reqs_taken;
  int  verdicts_seen;
  int  mismatches;
  bit  in_taken;
  bit  steady;
  int  send_gap;
  int  stall_left;
  int  hold_left;
  int  hold_mark;

  // Predictor state: a private copy of the capture state and the registers.
  cap_mode_t cap_mode;
  int        frame_pos;
  longint    mag_sum;
  int        write_frame;
  int        kept_frames;
  int        speech_run;
  int        quiet_run;
  bit        button_held;
  int        loud_level;
  int        pre_roll;
  int        min_speech;
  int        end_silence;
  int        max_speech;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #RUN_LIMIT;
    $display("energy_voice_endpoint_detector_tb NOT OK");
    $finish;
  end

  function automatic void clear_capture_state();
    frame_pos   = 0;
    mag_sum     = 0;
    write_frame = 0;
    kept_frames = 0;
    speech_run  = 0;
    quiet_run   = 0;
  endfunction

  // Advances the predicted detector by one accepted request and returns the
  // result that request must produce.
  function automatic res_t advance_detector(input audio_req_t req);
    res_t             r;
    int               mag;
    int               keep;
    bit               en;
    bit               loud;
    bit               ended;
    bit               full;
    logic [ADDR_W-1:0] addr;
    logic [LEN_W-1:0]  len;
    logic [START_W-1:0] first;
    r = '0;
    // The button latch collects presses on every request, whatever its kind.
    if (req.btn) button_held = 1'b1;
    if (req.op == OP_ARM) begin
      clear_capture_state();
      cap_mode = CAP_WAIT;
      return r;
    end
    if (cap_mode == CAP_IDLE) return r;
    // Button and deadline are only looked at when a frame begins; the sample
    // that carries the decision is dropped.
    if (frame_pos == 0) begin
      if (button_held) begin
        button_held = 1'b0;
        cap_mode    = CAP_IDLE;
        r.done      = 1'b1;
        r.outcome   = OUTCOME_BUTTON;
        return r;
      end
      if (cap_mode == CAP_WAIT && req.late) begin
        cap_mode  = CAP_IDLE;
        r.done    = 1'b1;
        r.outcome = OUTCOME_TIMEOUT;
        return r;
      end
    end
    mag = req.pcm[15] ? 65536 - int'(req.pcm) : int'(req.pcm);
    mag_sum += mag;
    en = (cap_mode == CAP_WAIT) || (kept_frames < STORE_FRAMES);
    r.en = en;
    if (en) begin
      addr   = ADDR_W'(write_frame * FRAME_LEN + frame_pos);
      r.addr = addr;
    end
    frame_pos++;
    if (frame_pos >= FRAME_LEN) begin
      loud      = (mag_sum / FRAME_LEN) >= loud_level;
      frame_pos = 0;
      mag_sum   = 0;
      if (cap_mode == CAP_WAIT) begin
        // Pre-roll of zero keeps one frame; anything past the store is cut.
        keep = (pre_roll == 0) ? 1 : pre_roll;
        if (keep > STORE_FRAMES) keep = STORE_FRAMES;
        write_frame = (write_frame + 1) % STORE_FRAMES;
        kept_frames = (kept_frames + 1 > keep) ? keep : kept_frames + 1;
        // The onset frame itself never ends the phrase.
        if (loud) begin
          cap_mode   = CAP_SPEECH;
          speech_run = 0;
          quiet_run  = 0;
        end
      end else begin
        if (en) begin
          write_frame = (write_frame + 1) % STORE_FRAMES;
          kept_frames++;
        end
        speech_run = (speech_run >= SAT_LIMIT) ? SAT_LIMIT : speech_run + 1;
        if (loud) quiet_run = 0;
        else quiet_run = (quiet_run >= SAT_LIMIT) ? SAT_LIMIT : quiet_run + 1;
        ended = speech_run >= min_speech && quiet_run >= end_silence;
        full  = speech_run >= max_speech || kept_frames >= STORE_FRAMES;
        if (ended || full) begin
          len       = LEN_W'(kept_frames);
          first     = START_W'((write_frame + STORE_FRAMES - kept_frames % STORE_FRAMES)
                               % STORE_FRAMES);
          r.done    = 1'b1;
          r.outcome = OUTCOME_SPEECH;
          r.len     = len;
          r.start   = first;
          cap_mode  = CAP_IDLE;
        end
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [39:0] exp,
                             input logic [39:0] act);
    if (act !== exp) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
      mismatches++;
    end
  endtask

  // Monitor: results are checked before the request of the same edge is
  // predicted, since a result always comes out of a register after its request.
  always @(posedge clk) begin : watch_results
    res_t want;
    in_taken = rst_n && in_tvalid && in_tready;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        verdicts_seen++;
        if (sample_verdicts.size() == 0) begin
          $display("%0t: result with no request pending, expected none, got %0h",
                   $time, out_tdata);
          mismatches++;
        end else begin
          want = sample_verdicts.pop_front();
          check_field("store_enable", want.en, out_tdata[0]);
          check_field("store_address", want.addr, out_tdata[17:1]);
          check_field("length_frames", want.len, out_tdata[26:18]);
          check_field("start_frame", want.start, out_tdata[34:27]);
          check_field("tdata padding", '0, out_tdata[OUT_DATA_W-1:35]);
          check_field("outcome", want.outcome, out_tuser);
          check_field("done", want.done, out_tlast);
        end
      end
      if (in_taken) begin
        reqs_taken++;
        sample_verdicts.push_back(advance_detector({in_tuser, in_tdata[17], in_tdata[16],
                                                    in_tdata[15:0]}));
      end
    end
  end

  // Driver: a request stays on the bus until it is taken, then an occasional
  // burst of empty cycles follows.
  always @(negedge clk) begin : feed_pcm
    audio_req_t req;
    if (!in_tvalid || in_taken) begin
      if (send_gap > 0) begin
        send_gap--;
        in_tvalid <= 1'b0;
      end else if (pcm_backlog.size() != 0) begin
        req = pcm_backlog.pop_front();
        in_tvalid <= 1'b1;
        in_tuser  <= req.op;
        in_tdata  <= {req.late, req.btn, req.pcm};
        if (!steady && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 6);
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: short random stalls, and every so often a long hold-off that
  // lets the skid register fill so the input side has to back off.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!steady && verdicts_seen >= hold_mark) begin
      hold_mark += 400;
      hold_left = $urandom_range(40, 80);
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if (!steady && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 6);
    end
  end

  task automatic push_req(input logic op, input logic [15:0] pcm, input logic btn,
                          input logic late);
    audio_req_t req;
    req.op   = op;
    req.pcm  = pcm;
    req.btn  = btn;
    req.late = late;
    pcm_backlog.push_back(req);
    reqs_queued++;
  endtask

  // Blocks until every queued request is taken and every result checked.
  // Each request yields a result, so the output stream is empty at that point.
  task automatic wait_drained();
    while (reqs_taken != reqs_queued || sample_verdicts.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value[15:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_ENERGY_THR:  loud_level  = value & 16'hFFFF;
      REG_PRE_ROLL:    pre_roll    = value & 9'h1FF;
      REG_MIN_SPEECH:  min_speech  = value & 12'hFFF;
      REG_END_SILENCE: end_silence = value & 12'hFFF;
      REG_MAX_SPEECH:  max_speech  = value & 12'hFFF;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input int thr, input int pre, input int min_frames,
                                input int sil_frames, input int max_frames);
    write_reg(REG_ENERGY_THR, thr);
    write_reg(REG_PRE_ROLL, pre);
    write_reg(REG_MIN_SPEECH, min_frames);
    write_reg(REG_END_SILENCE, sil_frames);
    write_reg(REG_MAX_SPEECH, max_frames);
  endtask

  // Queues one frame (or the first count samples of one) whose mean magnitude
  // lands on the requested side of the current threshold. A quarter of the
  // frames sit right on the boundary: exactly the threshold when loud, one
  // unit of total energy short of it when quiet.
  task automatic queue_frame(input bit want_loud, input int press_at, input bit late_start,
                             input int count);
    int          lo;
    int          hi;
    int          m;
    bit          border;
    logic [15:0] pcm;
    border = loud_level >= 1 && loud_level <= 32768 && $urandom_range(0, 3) == 0;
    lo = 0;
    hi = 32768;
    if (loud_level >= 1 && loud_level <= 32768) begin
      if (want_loud) lo = loud_level;
      else hi = loud_level - 1;
    end
    for (int i = 0; i < count; i++) begin
      if (border) m = (!want_loud && i == 0) ? loud_level - 1 : loud_level;
      else m = $urandom_range(hi, lo);
      pcm = m[15:0];
      if (m == 32768 || $urandom_range(0, 1) == 1) pcm = ~pcm + 16'd1;
      // The deadline flag only matters on the first sample of a frame.
      push_req(OP_SAMPLE, pcm, i == press_at,
               (i == 0) ? late_start : ($urandom_range(0, 3) == 0));
    end
  endtask

  // An arm request followed by quiet lead-in frames, a talk spurt and a
  // quiet tail. Unless clean, it may carry button presses, deadlines at frame
  // starts, stray loudness and a frame cut short by the next arm.
  task automatic queue_capture(input int lead, input int talk, input int tail,
                               input bit clean);
    int press;
    int cut;
    bit loud;
    push_req(OP_ARM, 16'($urandom), !clean && $urandom_range(0, 19) == 0,
             1'($urandom_range(0, 1)));
    for (int f = 0; f < lead + talk + tail; f++) begin
      if (f < lead) loud = 1'b0;
      else if (f < lead + talk) loud = clean || $urandom_range(0, 99) < 85;
      else loud = !clean && $urandom_range(0, 99) < 10;
      press = -1;
      if (!clean && $urandom_range(0, 14) == 0) press = $urandom_range(0, FRAME_LEN - 1);
      cut = FRAME_LEN;
      if (!clean && $urandom_range(0, 19) == 0) cut = $urandom_range(1, FRAME_LEN - 1);
      queue_frame(loud, press, !clean && $urandom_range(0, 11) == 0, cut);
      if (cut < FRAME_LEN) break;
    end
  endtask

  // Loose arm, sample, button and deadline requests under a random register
  // setting, so captures end on presses and deadlines at frame starts.
  task automatic noise_phase(input int count);
    int thr;
    case ($urandom_range(0, 3))
      0: thr = $urandom_range(1, 50);
      1: thr = $urandom_range(100, 3000);
      2: thr = $urandom_range(33000, 65535);
      default: thr = 0;
    endcase
    apply_settings(thr, $urandom_range(0, 5), $urandom_range(0, 3), $urandom_range(0, 3),
                   $urandom_range(0, 6));
    repeat (count)
      push_req($urandom_range(0, 3) == 0, 16'($urandom), $urandom_range(0, 7) == 0,
               1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  initial begin
    rst_n      = 1'b0;
    cfg_we     = 1'b0;
    cfg_addr   = REG_ENERGY_THR;
    cfg_wdata  = '0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = OP_SAMPLE;
    out_tready = 1'b0;
    steady     = 1'b0;
    hold_mark  = 200;
    cap_mode    = CAP_IDLE;
    button_held = 1'b0;
    loud_level  = ENERGY_THR_RST;
    pre_roll    = PRE_ROLL_RST;
    min_speech  = MIN_SPEECH_RST;
    end_silence = END_SILENCE_RST;
    max_speech  = MAX_SPEECH_RST;
    clear_capture_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed requests at the reset register values.
    push_req(OP_SAMPLE, 16'h7FFF, 1'b0, 1'b0);   // sample while idle is ignored
    push_req(OP_SAMPLE, 16'h8000, 1'b0, 1'b1);   // deadline while idle is ignored too
    push_req(OP_ARM, 16'h0000, 1'b0, 1'b0);
    push_req(OP_SAMPLE, 16'h1234, 1'b0, 1'b1);   // deadline at frame start: timeout
    push_req(OP_SAMPLE, 16'h0001, 1'b1, 1'b0);   // idle, but the press is latched
    push_req(OP_ARM, 16'hFFFF, 1'b0, 1'b0);
    push_req(OP_SAMPLE, 16'h4000, 1'b0, 1'b1);   // latch beats the deadline
    push_req(OP_ARM, 16'h0000, 1'b1, 1'b0);      // press riding on the arm request
    push_req(OP_SAMPLE, 16'h0000, 1'b0, 1'b0);   // ends on the button
    push_req(OP_ARM, 16'h5A5A, 1'b0, 1'b1);
    push_req(OP_SAMPLE, 16'h8000, 1'b0, 1'b0);   // stored at address zero
    push_req(OP_SAMPLE, 16'h7FFF, 1'b0, 1'b1);   // deadline mid-frame has no effect
    push_req(OP_SAMPLE, 16'hFFFF, 1'b0, 1'b0);
    push_req(OP_SAMPLE, 16'h0001, 1'b0, 1'b0);
    push_req(OP_SAMPLE, 16'h0000, 1'b1, 1'b0);   // press mid-frame waits for frame start
    push_req(OP_ARM, 16'hA5A5, 1'b0, 1'b0);      // restart while capturing
    push_req(OP_SAMPLE, 16'h5555, 1'b0, 1'b0);   // the held press ends it here
    wait_drained();

    // One short phrase: a loud onset frame, then a quiet frame that ends it
    // at once, since one quiet frame is enough and no minimum length applies.
    // The receiver's long hold-off lands in this stretch.
    apply_settings(1000, 300, 0, 1, 4095);
    queue_capture(0, 1, 1, 1'b1);
    wait_drained();

    // Closing stretch with both sides running flat out.
    steady = 1'b1;
    noise_phase(48);

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("energy_voice_endpoint_detector_tb OK");
    end else begin
      $display("energy_voice_endpoint_detector_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/evepd_pkg.sv
rtl/core/energy_voice_endpoint_detector.sv
bench/energy_voice_endpoint_detector_tb.sv
